// ===== rtl/sgru_pkg.sv =====
// ----------------------------------------------------------------------------
// sgru_pkg
// Shared widths, register indexes, sequencer codes and the sigmoid table
// of the scalar GRU cell.
// ----------------------------------------------------------------------------
package sgru_pkg;

  localparam int DATA_W     = 16;
  localparam int FRAC_W     = 12;
  localparam int SUM_W      = 31;
  localparam int SIG_ADDR_W = 8;

  localparam int SIG_ADDR_USED = (SIG_ADDR_W < DATA_W) ? SIG_ADDR_W : DATA_W;
  localparam int SIG_DEPTH     = 1 << SIG_ADDR_USED;

  // multiplier operands hold a signed sample/weight or an unsigned Q1.F value
  localparam int MUL_W  = ((DATA_W > FRAC_W + 1) ? DATA_W : FRAC_W + 1) + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int PRE_W  = ACC_W - FRAC_W;

  localparam int REG_COUNT = 6;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_U_UPDATE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_U_RESET  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_U_CAND   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_W_UPDATE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_W_RESET  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_W_CAND   = 3'd5;

  typedef logic [FRAC_W:0]        ufrac_t;
  typedef logic [DATA_W-1:0]      data_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic signed [MUL_W-1:0] mul_op_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam ufrac_t ONE_Q     = ufrac_t'(1 << FRAC_W);
  localparam sum_t   SUM_MAX   = {SUM_W{1'b1}};

  typedef enum logic [3:0] {
    OP_X_UZ,
    OP_S_WZ,
    OP_X_UR,
    OP_S_WR,
    OP_S_R,
    OP_X_UH,
    OP_SR_WH,
    OP_ZC_H,
    OP_Z_S
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_POST,
    ST_SUM
  } st_t;

  typedef struct packed {
    op_t  op;
    logic mul_en;
    logic acc_en;
    logic acc_clr;
    logic post_en;
    logic sum_en;
  } ctrl_t;

  // --------------------------------------------------------------------------
  // Sigmoid table, built at elaboration only
  // --------------------------------------------------------------------------
  localparam int           EXP_FRAC     = 30;
  localparam int           EXP_HALVINGS = 10;
  localparam logic [63:0]  EXP_ONE      = 64'd1 << EXP_FRAC;
  localparam logic [63:0]  SIG_CLAMP    = 64'd32 << FRAC_W;

  typedef ufrac_t sig_rom_t [SIG_DEPTH];

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b + (EXP_ONE >> 1)) >> EXP_FRAC;
  endfunction

  // restoring shift-subtract quotient
  function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] dv);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, dv}) begin
        rem  = rem - {1'b0, dv};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg(logic [63:0] t_in);
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] q;
    t = (t_in > SIG_CLAMP) ? SIG_CLAMP : t_in;
    d = (t << EXP_FRAC) >> (FRAC_W + EXP_HALVINGS);
    q = EXP_ONE - d / 64'd5;
    q = EXP_ONE - qmul(d, q) / 64'd4;
    q = EXP_ONE - qmul(d, q) / 64'd3;
    q = EXP_ONE - qmul(d, q) / 64'd2;
    q = EXP_ONE - qmul(d, q);
    for (int i = 0; i < EXP_HALVINGS; i++) begin
      q = qmul(q, q);
    end
    return q;
  endfunction

  function automatic ufrac_t sigmoid_at(longint v);
    logic [63:0] t;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] res;
    t   = (v < 0) ? 64'(-v) : 64'(v);
    e   = exp_neg(t);
    den = EXP_ONE + e;
    num = (v >= 0) ? (64'd1 << (FRAC_W + EXP_FRAC)) : (e << FRAC_W);
    res = udiv(num + (den >> 1), den);
    return res[FRAC_W:0];
  endfunction

  function automatic sig_rom_t build_sig_rom();
    sig_rom_t rom;
    longint   lo;
    longint   half;
    longint   shift;
    shift = DATA_W - SIG_ADDR_USED;
    lo    = -(longint'(1) <<< (DATA_W - 1));
    half  = (shift > 0) ? (longint'(1) <<< (shift - 1)) : 0;
    for (int k = 0; k < SIG_DEPTH; k++) begin
      rom[k] = sigmoid_at(lo + (longint'(k) <<< shift) + half);
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ===== rtl/sgru_mac.sv =====
// ----------------------------------------------------------------------------
// sgru_mac
// Shared multiply-accumulate unit: registered signed product, then an
// accumulator that either loads the product or adds it.
// ----------------------------------------------------------------------------
module sgru_mac (
  input  logic             clk,
  input  sgru_pkg::mul_op_t op_a,
  input  sgru_pkg::mul_op_t op_b,
  input  logic             mul_en,
  input  logic             acc_en,
  input  logic             acc_clr,
  output sgru_pkg::acc_t   acc
);

  logic signed [sgru_pkg::PROD_W-1:0] prod_r;
  sgru_pkg::acc_t                     acc_r;
  sgru_pkg::acc_t                     acc_nxt;
  sgru_pkg::acc_t                     prod_ext;

  assign prod_ext = sgru_pkg::ACC_W'(prod_r);

  always_comb begin
    if (acc_clr) begin
      acc_nxt = prod_ext;
    end else begin
      acc_nxt = acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/sgru_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgru_ctrl
// Sequencer: walks the nine multiply steps of one GRU update through the
// shared MAC, then commits the new state and running sum.
// ----------------------------------------------------------------------------
module sgru_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_busy,
  output logic            in_ready,
  output sgru_pkg::ctrl_t ctl
);

  sgru_pkg::st_t state_r;
  sgru_pkg::st_t state_nxt;
  sgru_pkg::op_t op_r;
  sgru_pkg::op_t op_nxt;
  logic          op_first;
  logic          op_last;

  // first step of each product pair, and the lone s*r step, starts a fresh accumulation
  always_comb begin
    case (op_r)
      sgru_pkg::OP_X_UZ, sgru_pkg::OP_X_UR, sgru_pkg::OP_S_R,
      sgru_pkg::OP_X_UH, sgru_pkg::OP_ZC_H: op_first = 1'b1;
      default:                              op_first = 1'b0;
    endcase
  end

  // steps after which the accumulator holds a finished value
  always_comb begin
    case (op_r)
      sgru_pkg::OP_S_WZ, sgru_pkg::OP_S_WR, sgru_pkg::OP_S_R,
      sgru_pkg::OP_SR_WH, sgru_pkg::OP_Z_S: op_last = 1'b1;
      default:                              op_last = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      sgru_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sgru_pkg::ST_MUL;
          op_nxt    = sgru_pkg::OP_X_UZ;
        end
      end
      sgru_pkg::ST_MUL: begin
        state_nxt = sgru_pkg::ST_ACC;
      end
      sgru_pkg::ST_ACC: begin
        if (op_last) begin
          state_nxt = sgru_pkg::ST_POST;
        end else begin
          state_nxt = sgru_pkg::ST_MUL;
          op_nxt    = sgru_pkg::op_t'(op_r + 4'd1);
        end
      end
      sgru_pkg::ST_POST: begin
        if (op_r == sgru_pkg::OP_Z_S) begin
          state_nxt = sgru_pkg::ST_SUM;
        end else begin
          state_nxt = sgru_pkg::ST_MUL;
          op_nxt    = sgru_pkg::op_t'(op_r + 4'd1);
        end
      end
      sgru_pkg::ST_SUM: begin
        if (!out_busy) begin
          state_nxt = sgru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sgru_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctl         = '0;
    ctl.op      = op_r;
    in_ready    = 1'b0;
    case (state_r)
      sgru_pkg::ST_IDLE: in_ready = 1'b1;
      sgru_pkg::ST_MUL:  ctl.mul_en = 1'b1;
      sgru_pkg::ST_ACC: begin
        ctl.acc_en  = 1'b1;
        ctl.acc_clr = op_first;
      end
      sgru_pkg::ST_POST: ctl.post_en = 1'b1;
      sgru_pkg::ST_SUM:  ctl.sum_en  = !out_busy;
      default:           ctl.op      = op_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgru_pkg::ST_IDLE;
      op_r    <= sgru_pkg::OP_X_UZ;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

// ===== rtl/scalar_gru_cell_step.sv =====
// ----------------------------------------------------------------------------
// scalar_gru_cell_step
// One time step of a scalar GRU neuron with a saturating state sum.
// ----------------------------------------------------------------------------
// Each transfer on the input side runs one GRU step on a Q4.12 sample: update
// gate, reset gate and candidate through a sigmoid table, then the blended
// new state in Q1.12, returned with a saturating running sum of all states
// since reset. All nine products go through one shared multiply-accumulate
// unit, each in a multiply step and an accumulate step, with a post step per
// gate/rounding result and a final sum step; a new item is taken only after
// the sum step. The result sits in an output register, so the next item may
// start while it waits. The previous state is zero after reset and is cleared
// after an item flagged last_in_seq; the running sum is only cleared by reset.
// Weights must be written through the cfg_ port while the block is idle, a
// rule the block leaves to the user; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module scalar_gru_cell_step (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sgru_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  logic [sgru_pkg::DATA_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [sgru_pkg::DATA_W-1:0] in_x_in,
  input  logic                               in_last_in_seq,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sgru_pkg::FRAC_W:0]          out_state_out,
  output logic [sgru_pkg::SUM_W-1:0]         out_running_sum,
  output logic                               out_sum_saturated
);

  sgru_pkg::data_t   cfg_r [sgru_pkg::REG_COUNT];
  sgru_pkg::data_t   x_r;
  logic              last_r;
  sgru_pkg::ufrac_t  s_r;
  sgru_pkg::ufrac_t  z_r;
  sgru_pkg::ufrac_t  r_r;
  sgru_pkg::ufrac_t  sr_r;
  sgru_pkg::ufrac_t  h_r;
  sgru_pkg::ufrac_t  ns_r;
  sgru_pkg::sum_t    sum_r;
  sgru_pkg::sum_t    sum_nxt;
  logic              out_valid_r;
  sgru_pkg::ufrac_t  out_state_r;
  sgru_pkg::sum_t    out_sum_r;
  logic              out_sat_r;

  sgru_pkg::ctrl_t   ctl;
  logic              out_busy;
  sgru_pkg::mul_op_t op_a;
  sgru_pkg::mul_op_t op_b;
  sgru_pkg::acc_t    acc;

  logic signed [sgru_pkg::PRE_W-1:0] pre;
  logic                              pos_ovf;
  logic                              neg_ovf;
  sgru_pkg::data_t                   pre_sat;
  logic [sgru_pkg::SIG_ADDR_USED-1:0] sig_idx;
  sgru_pkg::ufrac_t                  sig_val;
  sgru_pkg::ufrac_t                  rnd_val;
  logic [sgru_pkg::SUM_W:0]          sum_wide;

  function automatic sgru_pkg::mul_op_t sext_op(sgru_pkg::data_t v);
    return sgru_pkg::mul_op_t'(signed'(v));
  endfunction

  function automatic sgru_pkg::mul_op_t uext_op(sgru_pkg::ufrac_t v);
    return sgru_pkg::mul_op_t'({1'b0, v});
  endfunction

  assign out_busy = out_valid_r && !out_ready;

  sgru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // operand select per sequencer step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctl.op)
      sgru_pkg::OP_X_UZ: begin
        op_a = sext_op(x_r);
        op_b = sext_op(cfg_r[sgru_pkg::REG_U_UPDATE]);
      end
      sgru_pkg::OP_S_WZ: begin
        op_a = uext_op(s_r);
        op_b = sext_op(cfg_r[sgru_pkg::REG_W_UPDATE]);
      end
      sgru_pkg::OP_X_UR: begin
        op_a = sext_op(x_r);
        op_b = sext_op(cfg_r[sgru_pkg::REG_U_RESET]);
      end
      sgru_pkg::OP_S_WR: begin
        op_a = uext_op(s_r);
        op_b = sext_op(cfg_r[sgru_pkg::REG_W_RESET]);
      end
      sgru_pkg::OP_S_R: begin
        op_a = uext_op(s_r);
        op_b = uext_op(r_r);
      end
      sgru_pkg::OP_X_UH: begin
        op_a = sext_op(x_r);
        op_b = sext_op(cfg_r[sgru_pkg::REG_U_CAND]);
      end
      sgru_pkg::OP_SR_WH: begin
        op_a = uext_op(sr_r);
        op_b = sext_op(cfg_r[sgru_pkg::REG_W_CAND]);
      end
      sgru_pkg::OP_ZC_H: begin
        op_a = uext_op(sgru_pkg::ONE_Q - z_r);
        op_b = uext_op(h_r);
      end
      sgru_pkg::OP_Z_S: begin
        op_a = uext_op(z_r);
        op_b = uext_op(s_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  sgru_mac u_mac (
    .clk     (clk),
    .op_a    (op_a),
    .op_b    (op_b),
    .mul_en  (ctl.mul_en),
    .acc_en  (ctl.acc_en),
    .acc_clr (ctl.acc_clr),
    .acc     (acc)
  );

  // floor to integer Q, saturate to the sample range, index the table
  assign pre     = sgru_pkg::PRE_W'(acc >>> sgru_pkg::FRAC_W);
  assign pos_ovf = !pre[sgru_pkg::PRE_W-1] && (|pre[sgru_pkg::PRE_W-2:sgru_pkg::DATA_W-1]);
  assign neg_ovf = pre[sgru_pkg::PRE_W-1] && !(&pre[sgru_pkg::PRE_W-2:sgru_pkg::DATA_W-1]);

  always_comb begin
    if (pos_ovf) begin
      pre_sat = {1'b0, {(sgru_pkg::DATA_W-1){1'b1}}};
    end else if (neg_ovf) begin
      pre_sat = {1'b1, {(sgru_pkg::DATA_W-1){1'b0}}};
    end else begin
      pre_sat = pre[sgru_pkg::DATA_W-1:0];
    end
  end

  assign sig_idx = {~pre_sat[sgru_pkg::DATA_W-1],
                    pre_sat[sgru_pkg::DATA_W-2 -: (sgru_pkg::SIG_ADDR_USED-1)]};
  assign sig_val = sgru_pkg::SIG_ROM[sig_idx];

  // round-half-up product; accumulator is non-negative on these steps
  assign rnd_val = sgru_pkg::ufrac_t'((acc + sgru_pkg::acc_t'(1 << (sgru_pkg::FRAC_W-1)))
                                      >>> sgru_pkg::FRAC_W);

  assign sum_wide = {1'b0, sum_r} + (sgru_pkg::SUM_W+1)'(ns_r);

  always_comb begin
    if (sum_wide > {1'b0, sgru_pkg::SUM_MAX}) begin
      sum_nxt = sgru_pkg::SUM_MAX;
    end else begin
      sum_nxt = sum_wide[sgru_pkg::SUM_W-1:0];
    end
  end

  // weights
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sgru_pkg::REG_COUNT; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_addr < sgru_pkg::REG_IDX_W'(sgru_pkg::REG_COUNT))) begin
      cfg_r[cfg_addr] <= cfg_wdata;
    end
  end

  // item capture and intermediate results
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r    <= in_x_in;
      last_r <= in_last_in_seq;
    end
    if (ctl.post_en) begin
      case (ctl.op)
        sgru_pkg::OP_S_WZ:  z_r  <= sig_val;
        sgru_pkg::OP_S_WR:  r_r  <= sig_val;
        sgru_pkg::OP_S_R:   sr_r <= rnd_val;
        sgru_pkg::OP_SR_WH: h_r  <= sig_val;
        sgru_pkg::OP_Z_S:   ns_r <= rnd_val;
        default:            ns_r <= ns_r;
      endcase
    end
    if (ctl.sum_en) begin
      out_state_r <= ns_r;
      out_sum_r   <= sum_nxt;
      out_sat_r   <= (sum_nxt == sgru_pkg::SUM_MAX);
    end
  end

  // recurrent state, running sum, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r         <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.sum_en) begin
        s_r   <= last_r ? '0 : ns_r;
        sum_r <= sum_nxt;
      end
      if (ctl.sum_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_state_out     = out_state_r;
  assign out_running_sum   = out_sum_r;
  assign out_sum_saturated = out_sat_r;

  // busy for the whole sequence once an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    s_r <= sgru_pkg::ONE_Q)
    else $error("recurrent state above 1.0");

  a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_r >= $past(sum_r)) || $past(!rst_n))
    else $error("running sum decreased");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sum_saturated == (out_running_sum == sgru_pkg::SUM_MAX)))
    else $error("saturation flag disagrees with running sum");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.sum_en |-> !(out_valid && !out_ready))
    else $error("pending result overwritten");

endmodule
